// ===== src/srr_pkg.sv =====
// srr_pkg: shared types and constants of the selective-repeat reorder receiver
// used by srr_csr, the top level and the port checker
`default_nettype none
package srr_pkg;

   // result word kinds
   typedef enum logic [1:0] {
      KIND_DELIVER = 2'd0,
      KIND_ACK     = 2'd1,
      KIND_FIN     = 2'd2
   } kind_type;

   // register indexes (byte address bit 2)
   localparam logic REG_WINDOW_SIZE = 1'b0;
   localparam logic REG_INIT_LAST   = 1'b1;

   localparam logic [5:0]  WINDOW_RESET = 6'd16;
   localparam logic [31:0] STALE_SPAN   = 32'd200;
   localparam int          SEQ_BITS     = 32;
   localparam int          LEN_BITS     = 8;

   // configuration seen by the sequencer
   typedef struct packed {
      logic [5:0]  window_size;
      logic        init_wr;
      logic [31:0] init_last;
   } cfg_type;

endpackage
`default_nettype wire

// ===== src/srr_ram.sv =====
// srr_ram: generic single-write, single-read RAM with registered read data
// no dependencies
`default_nettype none
module srr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule
`default_nettype wire

// ===== src/srr_csr.sv =====
// srr_csr: APB-style configuration registers (window size, initial last number)
// depends on srr_pkg
`default_nettype none
module srr_csr
   import srr_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic      [31:0] csr_prdata,
   output logic             csr_pready,
   output cfg_type          cfg
);
   logic [5:0]  window_ff;
   logic [31:0] init_ff;
   logic        wr_en;

   assign csr_pready = 1'b1;
   assign wr_en = csr_psel & csr_penable & csr_pwrite;

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= WINDOW_RESET;
         init_ff   <= '0;
      end else if (wr_en) begin
         if (csr_paddr[2] == REG_WINDOW_SIZE) begin
            window_ff <= csr_pwdata[5:0];
         end else begin
            init_ff <= csr_pwdata;
         end
      end
   end

   // read back
   always_comb begin
      if (csr_paddr[2] == REG_WINDOW_SIZE) begin
         csr_prdata = {26'd0, window_ff};
      end else begin
         csr_prdata = init_ff;
      end
   end

   assign cfg.window_size = window_ff;
   assign cfg.init_wr     = wr_en & (csr_paddr[2] == REG_INIT_LAST);
   assign cfg.init_last   = csr_pwdata;
endmodule
`default_nettype wire

// ===== src/selective_repeat_reorder_receiver.sv =====
// selective_repeat_reorder_receiver: receive window sequencer over one slot RAM
// depends on srr_pkg, srr_ram, srr_csr
//
// One packet word is taken at a time. A data packet first brings the head slot
// within the window (needed only after a window size change), then scans every
// slot of the window through the slot RAM, one slot a cycle, to find a
// duplicate; it is then stored, acknowledged, or dropped if too far ahead.
// After a store at the head, each in-order delivery passes through a RAM read
// and a result word, and a closing check leads to the acknowledgement; a
// packet stored ahead of the head goes from the store straight to its
// acknowledgement. A finish packet goes straight to its result word. Results
// go out through one output register, so the next packet word is taken while
// the last result still waits. Held bits sit in flip-flops and are cleared at
// once by reset and by a finish packet; the RAM needs no clearing pass.
`default_nettype none
module selective_repeat_reorder_receiver
   import srr_pkg::*;
#(
   parameter int MAX_WINDOW = 32,
   parameter int REF_BITS   = 16
) (
   input  wire logic clock,
   input  wire logic reset,
   // packet words
   input  wire logic req_tvalid,
   output logic      req_tready,
   // tdata from bit 0: seq_number, payload_ref, payload_len, zero fill
   input  wire logic [((SEQ_BITS+REF_BITS+LEN_BITS+7)/8)*8-1:0] req_tdata,
   // tuser: is_fin
   input  wire logic req_tuser,
   // result words
   output logic      rsp_tvalid,
   input  wire logic rsp_tready,
   // tdata from bit 0: number, out_ref, out_len, zero fill
   output logic [((SEQ_BITS+REF_BITS+LEN_BITS+7)/8)*8-1:0] rsp_tdata,
   // tuser: kind
   output logic [1:0] rsp_tuser,
   output logic       rsp_tlast,
   // configuration
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic      [31:0] csr_prdata,
   output logic             csr_pready
);
   localparam int IW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
   localparam int CW = $clog2(MAX_WINDOW + 1);
   localparam int EW = SEQ_BITS + REF_BITS + LEN_BITS;
   localparam int DW = ((EW + 7) / 8) * 8;

   typedef enum logic [9:0] {
      S_IDLE     = 10'b0000000001,
      S_MOD      = 10'b0000000010,
      S_SCAN     = 10'b0000000100,
      S_SCAN_END = 10'b0000001000,
      S_DECIDE   = 10'b0000010000,
      S_STORE    = 10'b0000100000,
      S_REL_RD   = 10'b0001000000,
      S_REL_OUT  = 10'b0010000000,
      S_ACK      = 10'b0100000000,
      S_FIN      = 10'b1000000000
   } state_type;

   cfg_type cfg;

   srr_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   state_type state_ff, state_in;
   logic [MAX_WINDOW-1:0] full_ff, full_in;
   logic [31:0]   last_ff, last_in;
   logic [IW-1:0] head_ff, head_in;
   logic [CW-1:0] held_ff, held_in;
   logic [CW-1:0] ahead_ff, ahead_in;
   logic [IW-1:0] scan_ff, scan_in;
   logic          pend_ff, pend_in;
   logic [IW-1:0] pend_idx_ff, pend_idx_in;
   logic          dup_ff, dup_in;
   logic          first_ff, first_in;
   logic [IW-1:0] slot_ff, slot_in;
   // accepted packet
   logic [31:0]         seq_ff;
   logic [REF_BITS-1:0] ref_ff;
   logic [7:0]          len_ff;
   // output register
   logic                out_valid_ff, out_valid_in;
   logic [1:0]          out_kind_ff, out_kind_in;
   logic [31:0]         out_num_ff, out_num_in;
   logic [REF_BITS-1:0] out_ref_ff, out_ref_in;
   logic [7:0]          out_len_ff, out_len_in;
   logic                out_last_ff, out_last_in;

   logic          ram_we;
   logic [IW-1:0] ram_rd_addr;
   logic [EW-1:0] ram_wdata, ram_rdata;
   logic [31:0]         rd_seq;
   logic [REF_BITS-1:0] rd_ref;
   logic [7:0]          rd_len;

   logic [CW-1:0] win;
   logic          req_acc;
   logic          out_free;
   logic          stale;
   logic [31:0]   seq_dist;
   logic [CW-1:0] free_sp;
   logic          too_far;
   logic [CW:0]   slot_sum;
   logic [CW:0]   head_next;

   // slot RAM: sequence, handle, length
   srr_ram #(.WIDTH(EW), .DEPTH(MAX_WINDOW)) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (slot_ff),
      .wr_data (ram_wdata),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rdata)
   );

   assign ram_wdata = {len_ff, ref_ff, seq_ff};
   assign rd_seq = ram_rdata[31:0];
   assign rd_ref = ram_rdata[32 +: REF_BITS];
   assign rd_len = ram_rdata[32+REF_BITS +: 8];

   // effective window size
   always_comb begin
      if (cfg.window_size == 6'd0) begin
         win = CW'(1);
      end else if (int'(cfg.window_size) > MAX_WINDOW) begin
         win = CW'(MAX_WINDOW);
      end else begin
         win = CW'(cfg.window_size);
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign req_acc    = req_tvalid & req_tready;
   assign out_free   = ~out_valid_ff | rsp_tready;

   // window position of the packet
   assign stale    = (last_ff - seq_ff) < STALE_SPAN;
   assign seq_dist = seq_ff - last_ff;
   assign free_sp  = (held_ff >= win) ? '0 : win - held_ff;
   assign too_far  = seq_dist > 32'(free_sp);
   assign slot_sum = (CW+1)'(head_ff) + (CW+1)'(seq_dist[CW-1:0] - CW'(1));
   assign head_next = (CW+1)'(head_ff) + (CW+1)'(1);

   assign ram_we      = (state_ff == S_STORE);
   assign ram_rd_addr = (state_ff == S_SCAN) ? scan_ff : head_ff;

   // sequencer
   always_comb begin
      state_in     = state_ff;
      full_in      = full_ff;
      last_in      = last_ff;
      head_in      = head_ff;
      held_in      = held_ff;
      ahead_in     = ahead_ff;
      scan_in      = scan_ff;
      pend_in      = 1'b0;
      pend_idx_in  = scan_ff;
      dup_in       = dup_ff;
      first_in     = first_ff;
      slot_in      = slot_ff;
      out_valid_in = out_valid_ff & ~rsp_tready;
      out_kind_in  = out_kind_ff;
      out_num_in   = out_num_ff;
      out_ref_in   = out_ref_ff;
      out_len_in   = out_len_ff;
      out_last_in  = out_last_ff;

      // duplicate compare on the registered RAM read of the scanned slot
      if (pend_ff && full_ff[pend_idx_ff] && rd_seq == seq_ff) begin
         dup_in = 1'b1;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_acc) begin
               state_in = req_tuser ? S_FIN : S_MOD;
            end
         end
         S_MOD: begin
            // bring the head slot back inside the window
            if (CW'(head_ff) >= win) begin
               head_in = IW'(CW'(head_ff) - win);
            end else begin
               state_in = S_SCAN;
               scan_in  = '0;
               dup_in   = 1'b0;
            end
         end
         S_SCAN: begin
            pend_in = 1'b1;
            if (CW'(scan_ff) == win - CW'(1)) begin
               state_in = S_SCAN_END;
            end else begin
               scan_in = scan_ff + IW'(1);
            end
         end
         S_SCAN_END: begin
            state_in = S_DECIDE;
         end
         S_DECIDE: begin
            if (dup_ff || stale) begin
               state_in = S_ACK;
            end else if (too_far) begin
               state_in = S_IDLE;
            end else begin
               state_in = S_STORE;
               slot_in  = (slot_sum >= (CW+1)'(win)) ? IW'(slot_sum - (CW+1)'(win))
                                                      : IW'(slot_sum);
            end
         end
         S_STORE: begin
            // packet written to its slot this cycle
            if (!full_ff[slot_ff]) begin
               held_in = held_ff + CW'(1);
               if (slot_ff != head_ff) begin
                  ahead_in = ahead_ff + CW'(1);
               end
            end
            full_in[slot_ff] = 1'b1;
            first_in = 1'b1;
            state_in = (slot_ff == head_ff) ? S_REL_RD : S_ACK;
         end
         S_REL_RD: begin
            if (full_ff[head_ff] && (first_ff || ahead_ff != '0)) begin
               state_in = S_REL_OUT;
            end else begin
               state_in = S_ACK;
            end
         end
         S_REL_OUT: begin
            // head slot data is on the RAM output
            if (out_free) begin
               out_valid_in = 1'b1;
               out_kind_in  = KIND_DELIVER;
               out_num_in   = rd_seq;
               out_ref_in   = rd_ref;
               out_len_in   = rd_len;
               out_last_in  = 1'b0;
               full_in[head_ff] = 1'b0;
               last_in = rd_seq;
               if (held_ff != '0) begin
                  held_in = held_ff - CW'(1);
               end
               if (!first_ff) begin
                  ahead_in = ahead_ff - CW'(1);
               end
               first_in = 1'b0;
               head_in  = (head_next == (CW+1)'(win)) ? '0 : IW'(head_next);
               state_in = S_REL_RD;
            end
         end
         S_ACK: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_kind_in  = KIND_ACK;
               out_num_in   = seq_ff;
               out_ref_in   = '0;
               out_len_in   = '0;
               out_last_in  = 1'b1;
               state_in     = S_IDLE;
            end
         end
         S_FIN: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_kind_in  = KIND_FIN;
               out_num_in   = seq_ff;
               out_ref_in   = '0;
               out_len_in   = '0;
               out_last_in  = 1'b1;
               last_in      = seq_ff;
               full_in      = '0;
               head_in      = '0;
               held_in      = '0;
               ahead_in     = '0;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // load of the initial last number; the user is to write it only while idle, the block does not enforce this
      if (cfg.init_wr) begin
         last_in = cfg.init_last;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         full_ff      <= '0;
         last_ff      <= '0;
         head_ff      <= '0;
         held_ff      <= '0;
         ahead_ff     <= '0;
         pend_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         full_ff      <= full_in;
         last_ff      <= last_in;
         head_ff      <= head_in;
         held_ff      <= held_in;
         ahead_ff     <= ahead_in;
         pend_ff      <= pend_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload and scan registers
   always_ff @(posedge clock) begin
      scan_ff     <= scan_in;
      pend_idx_ff <= pend_idx_in;
      dup_ff      <= dup_in;
      first_ff    <= first_in;
      slot_ff     <= slot_in;
      out_kind_ff <= out_kind_in;
      out_num_ff  <= out_num_in;
      out_ref_ff  <= out_ref_in;
      out_len_ff  <= out_len_in;
      out_last_ff <= out_last_in;
      if (req_acc) begin
         seq_ff     <= req_tdata[31:0];
         ref_ff     <= req_tdata[32 +: REF_BITS];
         len_ff     <= req_tdata[32+REF_BITS +: 8];
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = DW'({out_len_ff, out_ref_ff, out_num_ff});
   assign rsp_tuser  = out_kind_ff;
   assign rsp_tlast  = out_last_ff;
endmodule
`default_nettype wire

// ===== src/srr_checker.sv =====
// srr_checker: port-level checks of the reorder receiver result stream
// depends on srr_pkg; bound to selective_repeat_reorder_receiver
`default_nettype none
module srr_checker
   import srr_pkg::*;
#(
   parameter int DW = 56
) (
   input wire logic          clock,
   input wire logic          reset,
   input wire logic          rsp_tvalid,
   input wire logic          rsp_tready,
   input wire logic [DW-1:0] rsp_tdata,
   input wire logic [1:0]    rsp_tuser,
   input wire logic          rsp_tlast
);
   // no result word straight after reset
   assert property (@(posedge clock) $past(reset) |-> !rsp_tvalid)
      else $error("result word right after reset");

   // a stalled result word holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("stalled result word changed");

   // deliveries are never last, acknowledgements and finish always are
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tlast == (rsp_tuser != KIND_DELIVER)))
      else $error("last flag does not match kind");

   // only a delivery carries a handle and a length
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != KIND_DELIVER |-> rsp_tdata[DW-1:32] == '0)
      else $error("handle or length set on a non-delivery");

   // kind code three is never sent
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tuser != 2'd3)
      else $error("undefined result kind");
endmodule

bind selective_repeat_reorder_receiver srr_checker #(
   .DW(((SEQ_BITS + REF_BITS + LEN_BITS + 7) / 8) * 8)
) u_srr_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);
`default_nettype wire

// ===== tb/sv/selective_repeat_reorder_receiver_tb.sv =====
// selective_repeat_reorder_receiver_tb: self-checking bench for the reorder receiver
// packet words go in on req_, result words are checked in order against a window model
// depends on srr_pkg and the top level
`default_nettype none

import srr_pkg::*;

// window model and queue of expected result words
class srr_window_model;
   typedef struct packed {
      logic [1:0]  kind;
      logic [31:0] number;
      logic [15:0] out_ref;
      logic [7:0]  out_len;
      logic        last;
   } result_t;

   logic [31:0] seq_mem[32];
   logic [15:0] ref_mem[32];
   logic [7:0]  len_mem[32];
   bit          full[32];
   logic [31:0] last_in_order;
   int unsigned head, held, ahead;
   logic [5:0]  win_reg;
   result_t     pending[$];
   int          errors;

   function new();
      errors = 0;
      win_reg = WINDOW_RESET;
      last_in_order = 0;
      clear();
   endfunction

   function void clear();
      foreach (full[i]) full[i] = 0;
      head = 0; held = 0; ahead = 0;
   endfunction

   function void write_reg(logic idx, logic [31:0] val);
      if (idx == REG_WINDOW_SIZE) win_reg = val[5:0];
      else last_in_order = val;
   endfunction

   function void push(logic [1:0] k, logic [31:0] n, logic [15:0] r, logic [7:0] l,
                      bit lst);
      result_t e;
      e.kind = k; e.number = n; e.out_ref = r; e.out_len = l; e.last = lst;
      pending.push_back(e);
   endfunction

   // work out the results of one accepted packet word
   function void note_packet(bit fin, logic [31:0] seq, logic [15:0] pref,
                             logic [7:0] plen);
      int unsigned w, slot, freesp, h;
      logic [31:0] seq_gap;
      bit first;
      w = (win_reg == 0) ? 1 : (win_reg > 32) ? 32 : win_reg;
      if (fin) begin
         push(KIND_FIN, seq, 0, 0, 1);
         last_in_order = seq;
         clear();
         return;
      end
      head = head % w;
      for (int i = 0; i < w; i++)
         if (full[i] && seq_mem[i] == seq) begin
            push(KIND_ACK, seq, 0, 0, 1);
            return;
         end
      if (last_in_order - seq < STALE_SPAN) begin
         push(KIND_ACK, seq, 0, 0, 1);
         return;
      end
      seq_gap = seq - last_in_order;
      freesp = (held >= w) ? 0 : w - held;
      if (seq_gap > freesp) return;
      slot = (head + seq_gap - 1) % w;
      if (!full[slot]) begin
         held++;
         if (slot != head) ahead++;
      end
      seq_mem[slot] = seq; ref_mem[slot] = pref; len_mem[slot] = plen;
      full[slot] = 1;
      if (slot == head) begin
         first = 1;
         while (full[head] && (first || ahead > 0)) begin
            h = head;
            push(KIND_DELIVER, seq_mem[h], ref_mem[h], len_mem[h], 0);
            full[h] = 0;
            last_in_order = seq_mem[h];
            if (held > 0) held--;
            if (!first) ahead--;
            first = 0;
            head = (h + 1) % w;
         end
      end
      push(KIND_ACK, seq, 0, 0, 1);
   endfunction

   // compare one result word with the oldest expectation
   function void check_result(logic [1:0] k, logic [31:0] n, logic [15:0] r,
                              logic [7:0] l, logic lst);
      result_t e;
      if (pending.size() == 0) begin
         $error("unexpected result word kind %0d number %h", k, n);
         errors++;
         return;
      end
      e = pending.pop_front();
      if (k !== e.kind) begin
         $error("kind: expected %0d, got %0d", e.kind, k); errors++;
      end
      if (n !== e.number) begin
         $error("number: expected %h, got %h", e.number, n); errors++;
      end
      if (r !== e.out_ref) begin
         $error("out_ref: expected %h, got %h", e.out_ref, r); errors++;
      end
      if (l !== e.out_len) begin
         $error("out_len: expected %h, got %h", e.out_len, l); errors++;
      end
      if (lst !== e.last) begin
         $error("last: expected %0d, got %0d", e.last, lst); errors++;
      end
   endfunction
endclass

module selective_repeat_reorder_receiver_tb;
   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [55:0] req_tdata = '0;
   logic        req_tuser = 0;
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [55:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        rsp_tlast;
   logic        csr_psel = 0, csr_penable = 0, csr_pwrite = 0;
   logic [2:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   srr_window_model window_model;

   selective_repeat_reorder_receiver u_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser), .rsp_tlast(rsp_tlast),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata), .csr_pready(csr_pready)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // overall time limit
   initial begin
      #4000000;
      $display("TB_ERROR");
      $finish;
   end

   // register write: setup then access cycle
   task automatic reg_write(logic idx, logic [31:0] val);
      @(posedge clock);
      csr_psel <= 1; csr_penable <= 0; csr_pwrite <= 1;
      csr_paddr <= {idx, 2'b00}; csr_pwdata <= val;
      @(posedge clock);
      csr_penable <= 1;
      do @(posedge clock); while (!csr_pready);
      window_model.write_reg(idx, val);
      csr_psel <= 0; csr_penable <= 0; csr_pwrite <= 0;
   endtask

   // send one packet word after a random gap
   task automatic send_packet(bit fin, logic [31:0] seq, logic [15:0] pref,
                              logic [7:0] plen);
      int gap;
      gap = $urandom_range(0, 7);
      if ($urandom_range(0, 3) == 0) gap = 0;
      repeat (gap) begin
         @(posedge clock);
         req_tvalid <= 0;
      end
      @(posedge clock);
      req_tvalid <= 1; req_tuser <= fin;
      req_tdata <= {plen, pref, seq};
      do @(posedge clock); while (!req_tready);
      window_model.note_packet(fin, seq, pref, plen);
      req_tvalid <= 0;
   endtask

   // wait until every expected word has come, then let the block settle
   task automatic drain();
      int guard;
      guard = 0;
      while (window_model.pending.size() != 0 && guard < 20000) begin
         @(posedge clock);
         guard++;
      end
      repeat (120) @(posedge clock);
   endtask

   // burst of packets around the current last in-order number
   task automatic random_burst(int count, int unsigned win);
      logic [31:0] base;
      int unsigned sel;
      base = window_model.last_in_order;
      for (int i = 0; i < count; i++) begin
         sel = $urandom_range(0, 19);
         if (sel == 0)
            send_packet(1, $urandom, 16'($urandom), 8'($urandom));
         else if (sel == 1)
            send_packet(0, $urandom, 16'($urandom), 8'($urandom));
         else if (sel <= 3)
            send_packet(0, window_model.last_in_order - $urandom_range(0, 210),
                        16'($urandom), 8'($urandom));
         else
            send_packet(0, window_model.last_in_order + $urandom_range(1, win + 2),
                        16'($urandom), 8'($urandom));
      end
   endtask

   // result side: random stall, checks each word at its handshake
   initial begin
      int stall;
      window_model = new();
      forever begin
         stall = $urandom_range(0, 7);
         if ($urandom_range(0, 3) == 0) stall = 0;
         repeat (stall) begin
            @(posedge clock);
            rsp_tready <= 0;
         end
         @(posedge clock);
         rsp_tready <= 1;
         do begin
            @(posedge clock);
            if (rsp_tvalid && rsp_tready && !reset)
               window_model.check_result(rsp_tuser, rsp_tdata[31:0], rsp_tdata[47:32],
                                         rsp_tdata[55:48], rsp_tlast);
         end while (!(rsp_tvalid && rsp_tready));
         rsp_tready <= 0;
      end
   end

   initial begin
      logic [31:0] b;
      repeat (8) @(posedge clock);
      reset <= 0;
      repeat (2) @(posedge clock);

      // directed: reset window, extremes, duplicate, stale, too far, finish
      send_packet(0, 32'd2, 16'hFFFF, 8'hFF);
      send_packet(0, 32'd3, 16'h0000, 8'h00);
      send_packet(0, 32'd2, 16'h1234, 8'h12);
      send_packet(0, 32'd1, 16'h5555, 8'h55);
      send_packet(0, 32'd0, 16'hAAAA, 8'hAA);
      send_packet(0, 32'd200, 16'h0001, 8'h01);
      send_packet(0, -32'd199, 16'h0002, 8'h02);
      send_packet(0, -32'd200, 16'h0003, 8'h03);
      send_packet(0, 32'd17, 16'h0004, 8'h04);
      send_packet(1, 32'hFFFF_FFFE, 16'hFFFF, 8'hFF);
      send_packet(0, 32'hFFFF_FFFF, 16'h0101, 8'h10);
      send_packet(0, 32'd0, 16'h0202, 8'h20);
      drain();

      // wide window with wrap-around base
      reg_write(REG_WINDOW_SIZE, 32'd32);
      reg_write(REG_INIT_LAST, 32'hFFFF_FFF0);
      b = 32'hFFFF_FFF0;
      for (int i = 32; i >= 1; i--)
         send_packet(0, b + i, 16'($urandom), 8'($urandom));
      send_packet(0, b + 33, 16'h7777, 8'h77);
      drain();

      // smallest window, then out of range values
      reg_write(REG_WINDOW_SIZE, 32'd1);
      reg_write(REG_INIT_LAST, 32'h8000_0000);
      random_burst(20, 1);
      drain();
      reg_write(REG_WINDOW_SIZE, 32'd0);
      random_burst(10, 1);
      drain();
      reg_write(REG_WINDOW_SIZE, 32'd63);
      reg_write(REG_INIT_LAST, $urandom);
      random_burst(40, 32);
      drain();

      // window change with packets held
      reg_write(REG_WINDOW_SIZE, 32'd8);
      reg_write(REG_INIT_LAST, 32'd1000);
      send_packet(0, 32'd1003, 16'h00A0, 8'h0A);
      send_packet(0, 32'd1006, 16'h00B0, 8'h0B);
      drain();
      reg_write(REG_WINDOW_SIZE, 32'd5);
      random_burst(20, 5);
      drain();

      // random settings
      for (int p = 0; p < 4; p++) begin
         reg_write(REG_WINDOW_SIZE, $urandom_range(2, 32));
         reg_write(REG_INIT_LAST, $urandom);
         random_burst(16, 32'(window_model.win_reg));
         drain();
      end

      if (window_model.errors == 0 && window_model.pending.size() == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end
endmodule
`default_nettype wire
